### src/per_source_tcp_flood_detector_macros.svh
// assertion macros for the flood detector
// no dependencies; included by ptfd_dpath, the module that checks its own logic
`ifndef PER_SOURCE_TCP_FLOOD_DETECTOR_MACROS_SVH
`define PER_SOURCE_TCP_FLOOD_DETECTOR_MACROS_SVH
`ifndef SYNTH
`define PTFD_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");
`define PTFD_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define PTFD_ASSERT_IMPL(label, clk, rst_n, a, b)
`define PTFD_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### src/ptfd_pkg.sv
// shared types, constants and codes of the flood detector
// no dependencies
package ptfd_pkg;

    localparam int COUNT_ENTRIES_DEF = 64;
    localparam int BLOCK_ENTRIES_DEF = 64;

    localparam logic [7:0]  FLAG_ACK       = 8'h10;
    localparam logic [7:0]  FLAG_RST       = 8'h04;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    localparam logic [15:0] THRESHOLD_RST    = 16'd100;
    localparam logic [15:0] SERVICE_PORT_RST = 16'd25000;

    localparam logic       REQ_FRAME = 1'b0;
    localparam logic       REQ_TICK  = 1'b1;

    localparam logic       REG_THRESHOLD    = 1'b0;
    localparam logic       REG_SERVICE_PORT = 1'b1;

    localparam logic [2:0] V_IGNORED = 3'd0;
    localparam logic [2:0] V_DROP    = 3'd1;
    localparam logic [2:0] V_COUNTED = 3'd2;
    localparam logic [2:0] V_RESET   = 3'd3;
    localparam logic [2:0] V_FULL    = 3'd4;
    localparam logic [2:0] V_TICK    = 3'd5;

    typedef struct packed {
        logic        req_type;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [31:0] source_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  tcp_flags;
        logic [31:0] tcp_seq;
    } t_in;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [15:0] source_count;
        logic [15:0] reset_port;
        logic [31:0] reset_seq;
        logic        blacklist_full;
    } t_out;

    typedef struct packed {
        logic [31:0] key;
        logic [15:0] value;
    } t_centry;

    typedef struct packed {
        logic load;
        logic bstep;
        logic cstart;
        logic cstep;
        logic fin_tick;
        logic fin_check;
        logic fin_upd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic bdone;
        logic cdone;
        logic pass;
        logic out_free;
    } t_sts;

endpackage

### src/ptfd_ctrl.sv
// sequencer of the flood detector: walks one item through scan and update
// depends on ptfd_pkg
module ptfd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ptfd_pkg::t_sts  i_sts,
    output ptfd_pkg::t_cmd  o_cmd
);
    import ptfd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BSCAN = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_CSCAN = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_BSCAN;
                end
            end
            S_BSCAN: begin
                o_cmd.bstep = 1'b1;
                if (i_sts.bdone) n_state = S_CHECK;
            end
            S_CHECK: begin
                priority if (i_sts.is_tick) begin
                    o_cmd.fin_tick = 1'b1;
                    n_state        = S_DONE;
                end else if (!i_sts.pass) begin
                    o_cmd.fin_check = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.cstart = 1'b1;
                    n_state      = S_CSCAN;
                end
            end
            S_CSCAN: begin
                o_cmd.cstep = 1'b1;
                if (i_sts.cdone) n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.fin_upd = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

### src/ptfd_dpath.sv
// tables, scan engines, update logic and result register of the flood detector
// depends on ptfd_pkg and the assertion macro header
module ptfd_dpath #(
    parameter int COUNT_ENTRIES = ptfd_pkg::COUNT_ENTRIES_DEF,
    parameter int BLOCK_ENTRIES = ptfd_pkg::BLOCK_ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ptfd_pkg::t_in   i_in,
    input  logic [15:0]     i_threshold,
    input  logic [15:0]     i_service_port,
    input  ptfd_pkg::t_cmd  i_cmd,
    output ptfd_pkg::t_sts  o_sts,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output ptfd_pkg::t_out  o_out
);
    import ptfd_pkg::*;
    `include "per_source_tcp_flood_detector_macros.svh"

    localparam int CW = $clog2(COUNT_ENTRIES);
    localparam int BW = $clog2(BLOCK_ENTRIES);
    localparam logic [CW:0] C_DEPTH = (CW + 1)'(COUNT_ENTRIES);
    localparam logic [BW:0] B_DEPTH = (BW + 1)'(BLOCK_ENTRIES);

    t_in         r_item;
    t_out        r_res;
    t_out        r_out;
    logic        r_ovalid;

    // blacklist: filled from slot 0 upward, never cleared but by reset
    logic [31:0] r_bmem [BLOCK_ENTRIES];
    logic [31:0] r_bq;
    logic [BW:0] r_bfill, r_baddr;
    logic        r_bpend, r_bhit;

    // count table: filled from slot 0 upward, emptied by a tick
    t_centry     r_cmem [COUNT_ENTRIES];
    t_centry     r_cq;
    logic [CW:0] r_cfill, r_caddr;
    logic [CW-1:0] r_cpidx, r_cidx;
    logic        r_cpend, r_chit;
    logic [15:0] r_cval;

    logic        b_issue, b_match, c_issue, c_match;
    logic        is_ack, drop, ignore;
    logic [15:0] new_cnt;
    logic        c_full, trig, blk_add, blk_full;

    assign b_issue = i_cmd.bstep && (r_baddr < r_bfill);
    assign b_match = r_bpend && (r_bq == r_item.source_ip);
    assign c_issue = i_cmd.cstep && (r_caddr < r_cfill);
    assign c_match = r_cpend && (r_cq.key == r_item.source_ip);

    assign is_ack = (r_item.tcp_flags == FLAG_ACK);
    assign drop   = r_bhit && !is_ack;
    assign ignore = (r_item.ether_type != ETHERTYPE_IPV4) ||
                    (r_item.ip_protocol != PROTO_TCP) ||
                    (r_item.tcp_flags == FLAG_RST) ||
                    ((r_item.source_port != i_service_port) &&
                     (r_item.dest_port != i_service_port));

    assign new_cnt  = r_chit ? ((r_cval == COUNT_MAX) ? r_cval : r_cval + 16'd1) : 16'd1;
    assign c_full   = !r_chit && (r_cfill == C_DEPTH);
    assign trig     = !c_full && (new_cnt >= i_threshold) && is_ack;
    assign blk_add  = trig && !r_bhit && (r_bfill < B_DEPTH);
    assign blk_full = trig && !r_bhit && (r_bfill == B_DEPTH);

    // a scan ends on a hit or once every filled entry has been issued
    assign o_sts.is_tick  = (r_item.req_type == REQ_TICK);
    assign o_sts.bdone    = r_bhit || b_match || (r_baddr >= r_bfill);
    assign o_sts.cdone    = r_chit || c_match || (r_caddr >= r_cfill);
    assign o_sts.pass     = !drop && !ignore;
    assign o_sts.out_free = !r_ovalid || !i_out_stall;

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    // payload registers and memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_in;
        if (b_issue) r_bq <= r_bmem[r_baddr[BW-1:0]];
        if (c_issue) r_cq <= r_cmem[r_caddr[CW-1:0]];
        if (i_cmd.cstep) begin
            r_cpidx <= r_caddr[CW-1:0];
            if (c_match) begin
                r_cidx <= r_cpidx;
                r_cval <= r_cq.value;
            end
        end
        if (i_cmd.fin_upd) begin
            if (r_chit)
                r_cmem[r_cidx] <= '{key: r_item.source_ip, value: new_cnt};
            else if (!c_full)
                r_cmem[r_cfill[CW-1:0]] <= '{key: r_item.source_ip, value: new_cnt};
            if (blk_add) r_bmem[r_bfill[BW-1:0]] <= r_item.source_ip;
        end
        priority if (i_cmd.fin_tick) begin
            r_res         <= '0;
            r_res.verdict <= V_TICK;
        end else if (i_cmd.fin_check) begin
            r_res         <= '0;
            r_res.verdict <= drop ? V_DROP : V_IGNORED;
        end else if (i_cmd.fin_upd) begin
            r_res <= '0;
            if (c_full) begin
                r_res.verdict <= V_FULL;
            end else begin
                r_res.verdict        <= trig ? V_RESET : V_COUNTED;
                r_res.source_count   <= new_cnt;
                r_res.reset_port     <= trig ? r_item.source_port : 16'd0;
                r_res.reset_seq      <= trig ? r_item.tcp_seq : 32'd0;
                r_res.blacklist_full <= blk_full;
            end
        end
        if (i_cmd.emit) r_out <= r_res;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_bfill  <= '0;
            r_cfill  <= '0;
            r_baddr  <= '0;
            r_bpend  <= 1'b0;
            r_bhit   <= 1'b0;
            r_caddr  <= '0;
            r_cpend  <= 1'b0;
            r_chit   <= 1'b0;
        end else begin
            if (i_cmd.emit)        r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;

            if (i_cmd.load) begin
                r_baddr <= '0;
                r_bpend <= 1'b0;
                r_bhit  <= 1'b0;
            end else if (i_cmd.bstep) begin
                if (b_issue) r_baddr <= r_baddr + 1'b1;
                r_bpend <= b_issue;
                if (b_match) r_bhit <= 1'b1;
            end

            if (i_cmd.cstart) begin
                r_caddr <= '0;
                r_cpend <= 1'b0;
                r_chit  <= 1'b0;
            end else if (i_cmd.cstep) begin
                if (c_issue) r_caddr <= r_caddr + 1'b1;
                r_cpend <= c_issue;
                if (c_match) r_chit <= 1'b1;
            end

            if (i_cmd.fin_tick)
                r_cfill <= '0;
            else if (i_cmd.fin_upd && !r_chit && !c_full)
                r_cfill <= r_cfill + 1'b1;

            if (i_cmd.fin_upd && blk_add) r_bfill <= r_bfill + 1'b1;
        end
    end

    `PTFD_ASSERT_IMPL(a_cfill_bound, i_clk, i_rst_n, 1'b1, r_cfill <= C_DEPTH)
    `PTFD_ASSERT_IMPL(a_bfill_bound, i_clk, i_rst_n, 1'b1, r_bfill <= B_DEPTH)
    `PTFD_ASSERT_IMPL(a_emit_free, i_clk, i_rst_n, i_cmd.emit, o_sts.out_free)
    `PTFD_ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, i_cmd.emit, r_ovalid)

endmodule

### src/per_source_tcp_flood_detector.sv
// one item at a time: a counted frame is loaded, scanned against the blacklist, checked,
// scanned against the count table, updated and then handed to the output register
// ticks, drops and ignored frames skip the count scan and update; the next item is taken
// only once the last has been handed off, which waits while the output is stalled
// synchronous active-low reset: both tables empty, threshold 100, service port 25000
module per_source_tcp_flood_detector #(
    parameter int COUNT_ENTRIES = ptfd_pkg::COUNT_ENTRIES_DEF,
    parameter int BLOCK_ENTRIES = ptfd_pkg::BLOCK_ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // input beat channel
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ptfd_pkg::t_in   i_in,
    // result beat channel
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output ptfd_pkg::t_out  o_out,
    // configuration write channel
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_index,
    input  logic [15:0]     i_cfg_data
);
    import ptfd_pkg::*;

    logic [15:0] r_threshold;
    logic [15:0] r_service_port;
    t_cmd        cmd;
    t_sts        sts;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= THRESHOLD_RST;
            r_service_port <= SERVICE_PORT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_THRESHOLD:    r_threshold    <= i_cfg_data;
                REG_SERVICE_PORT: r_service_port <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // sequencer: scan blacklist, classify, scan counts and update (passing frames only), hand off
    ptfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // tables, compare and update, output register
    ptfd_dpath #(
        .COUNT_ENTRIES (COUNT_ENTRIES),
        .BLOCK_ENTRIES (BLOCK_ENTRIES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_threshold    (r_threshold),
        .i_service_port (r_service_port),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out          (o_out)
    );

endmodule
